/* rtl/core/dsp_eic_pkg.sv */
package dsp_eic_pkg;

  // Item operation codes
  localparam logic [1:0] OP_READ  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_PULSE = 2'd2;
  localparam logic [1:0] OP_IDLE  = 2'd3;

  // Register banks: word offset bits 6..2
  localparam logic [4:0] BANK_FLAG  = 5'd0;
  localparam logic [4:0] BANK_SET   = 5'd2;
  localparam logic [4:0] BANK_CLR   = 5'd4;
  localparam logic [4:0] BANK_MASK  = 5'd8;
  localparam logic [4:0] BANK_MFLAG = 5'd10;
  localparam logic [4:0] BANK_XMASK = 5'd12;
  localparam logic [4:0] BANK_XFLAG = 5'd14;
  localparam logic [4:0] BANK_MUX   = 5'd16;

  localparam int NUM_GROUPS    = 4;
  localparam int GROUP_W       = 32;
  localparam int SEL_W         = 7;
  localparam int NUM_SEL       = 12;
  localparam int SEL_PER_WORD  = 4;
  localparam int NUM_IRQ       = 16;
  localparam int FIXED_IRQS    = 4;

  // Events 0..3 are the combined lines and never hold a flag
  localparam logic [GROUP_W-1:0] RESERVED_KEEP = 32'hFFFF_FFF0;

  typedef struct packed {
    logic capture;  // load the input word register
    logic exec;     // apply the held word and load the result register
  } cmd_t;

endpackage

/* rtl/core/dsp_event_interrupt_controller.sv */
// Event interrupt controller for up to 128 system events in four groups of
// 32. Each input word is a bus read (op 0), a bus write (op 1), an event pulse
// for one group (op 2) or an idle op (op 3); every word yields exactly one
// result word carrying read data, the four combined-event lines, the
// exception line, the CPU interrupt pulse vector (interrupts 4..15, each fed
// by a 7-bit event selector) and a bus error bit. Register map by word offset,
// g = group: 0+g flags (RO), 8+g set (WO, write 1), 16+g clear (WO, write 1),
// 32+g event mask, 40+g masked flags (RO), 48+g exception mask, 56+g masked
// exception flags (RO), 65..67 interrupt mux words. Masks reset to all ones.
// Throughput is one word per clock while results are taken. The word is
// captured in an input register; the whole flag/mask update, the twelve
// selector lookups and the read mux are combinational and land in the
// result register. A result that is not taken holds one further word in
// the input register before in_ready drops.

module dsp_event_interrupt_controller #(
  parameter int EVENT_GROUPS       = 4,
  parameter int FIRST_MAPPABLE_IRQ = 4
) (
  input  logic        clk,
  input  logic        rst,
  // input channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  op,
  input  logic [6:0]  reg_word,
  input  logic [31:0] write_data,
  input  logic [1:0]  event_group,
  input  logic [31:0] event_bits,
  // result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] read_data,
  output logic [3:0]  combined_events,
  output logic        exception_out,
  output logic [15:0] cpu_irq_pulse,
  output logic        bad_access
);

  dsp_eic_pkg::cmd_t cmd;

  // handshake sequencing: word held / result held
  dsp_eic_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  // register file, event flags and interrupt mapping
  dsp_eic_datapath #(
    .EVENT_GROUPS       (EVENT_GROUPS),
    .FIRST_MAPPABLE_IRQ (FIRST_MAPPABLE_IRQ)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .op              (op),
    .reg_word        (reg_word),
    .write_data      (write_data),
    .event_group     (event_group),
    .event_bits      (event_bits),
    .read_data       (read_data),
    .combined_events (combined_events),
    .exception_out   (exception_out),
    .cpu_irq_pulse   (cpu_irq_pulse),
    .bad_access      (bad_access)
  );

endmodule

/* rtl/core/dsp_eic_ctrl.sv */
module dsp_eic_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  output dsp_eic_pkg::cmd_t   cmd
);

  // state = {result held, word held}
  localparam logic [1:0] ST_IDLE   = 2'b00;
  localparam logic [1:0] ST_ITEM   = 2'b01;
  localparam logic [1:0] ST_RESULT = 2'b10;
  localparam logic [1:0] ST_BOTH   = 2'b11;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       exec;

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    exec       = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) state_next = ST_ITEM;
      end
      ST_ITEM: begin
        in_ready   = 1'b1;
        exec       = 1'b1;
        state_next = in_valid ? ST_BOTH : ST_RESULT;
      end
      ST_RESULT: begin
        in_ready  = 1'b1;
        out_valid = 1'b1;
        if (in_valid) begin
          state_next = out_ready ? ST_ITEM : ST_BOTH;
        end else begin
          state_next = out_ready ? ST_IDLE : ST_RESULT;
        end
      end
      ST_BOTH: begin
        out_valid = 1'b1;
        in_ready  = out_ready;
        exec      = out_ready;
        if (out_ready) state_next = in_valid ? ST_BOTH : ST_RESULT;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign cmd.capture = in_valid && in_ready;
  assign cmd.exec    = exec;

endmodule

/* rtl/core/dsp_eic_datapath.sv */
module dsp_eic_datapath #(
  parameter int EVENT_GROUPS       = 4,
  parameter int FIRST_MAPPABLE_IRQ = 4
) (
  input  logic                clk,
  input  logic                rst,
  input  dsp_eic_pkg::cmd_t   cmd,
  input  logic [1:0]          op,
  input  logic [6:0]          reg_word,
  input  logic [31:0]         write_data,
  input  logic [1:0]          event_group,
  input  logic [31:0]         event_bits,
  output logic [31:0]         read_data,
  output logic [3:0]          combined_events,
  output logic                exception_out,
  output logic [15:0]         cpu_irq_pulse,
  output logic                bad_access
);

  localparam int NG = dsp_eic_pkg::NUM_GROUPS;
  localparam int GW = dsp_eic_pkg::GROUP_W;
  localparam int SW = dsp_eic_pkg::SEL_W;
  localparam int NS = dsp_eic_pkg::NUM_SEL;

  // held input word
  logic [1:0]    op_q;
  logic [6:0]    rw_q;
  logic [31:0]   wd_q;
  logic [1:0]    eg_q;
  logic [31:0]   eb_q;

  logic [GW-1:0] flags    [NG];
  logic [GW-1:0] masks    [NG];
  logic [GW-1:0] xmasks   [NG];
  logic [GW-1:0] flags_next  [NG];
  logic [GW-1:0] masks_next  [NG];
  logic [GW-1:0] xmasks_next [NG];
  logic [GW-1:0] raised   [NG];
  logic [SW-1:0] sel      [NS];
  logic [31:0]   mux_word [NG];
  logic [NG*GW-1:0] raised_all;

  logic [3:0]    last_comb;
  logic [3:0]    newc;
  logic [3:0]    rise;
  logic          exc;
  logic [15:0]   pulse;

  logic [4:0]    bank;
  logic [1:0]    grp;
  logic          grp_ok;
  logic          is_rd;
  logic          is_wr;
  logic [31:0]   rd;
  logic          bad;
  logic          set_en;
  logic          clr_en;
  logic          mask_we;
  logic          xmask_we;
  logic          mux_we;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_q <= op;
      rw_q <= reg_word;
      wd_q <= write_data;
      eg_q <= event_group;
      eb_q <= event_bits;
    end
  end

  assign bank   = rw_q[6:2];
  assign grp    = rw_q[1:0];
  assign grp_ok = int'(grp) < EVENT_GROUPS;
  assign is_rd  = op_q == dsp_eic_pkg::OP_READ;
  assign is_wr  = op_q == dsp_eic_pkg::OP_WRITE;

  // bus decode
  always_comb begin
    rd       = '0;
    bad      = 1'b0;
    set_en   = 1'b0;
    clr_en   = 1'b0;
    mask_we  = 1'b0;
    xmask_we = 1'b0;
    mux_we   = 1'b0;
    if (is_rd || is_wr) begin
      if (bank == dsp_eic_pkg::BANK_MUX) begin
        if (grp == 2'd0) begin
          bad = 1'b1;  // mux word 0 is not mapped
        end else if (is_wr) begin
          mux_we = 1'b1;
        end else begin
          rd = mux_word[grp];
        end
      end else if (!grp_ok) begin
        bad = 1'b1;
      end else begin
        case (bank)
          dsp_eic_pkg::BANK_FLAG: begin
            if (is_wr) bad = 1'b1; else rd = flags[grp];
          end
          dsp_eic_pkg::BANK_SET: begin
            set_en = is_wr;
          end
          dsp_eic_pkg::BANK_CLR: begin
            clr_en = is_wr;
          end
          dsp_eic_pkg::BANK_MASK: begin
            if (is_wr) mask_we = 1'b1; else rd = masks[grp];
          end
          dsp_eic_pkg::BANK_MFLAG: begin
            if (is_wr) bad = 1'b1; else rd = flags[grp] & ~masks[grp];
          end
          dsp_eic_pkg::BANK_XMASK: begin
            if (is_wr) xmask_we = 1'b1; else rd = xmasks[grp];
          end
          dsp_eic_pkg::BANK_XFLAG: begin
            if (is_wr) bad = 1'b1; else rd = flags[grp] & ~xmasks[grp];
          end
          default: begin
            bad = 1'b1;
          end
        endcase
      end
    end
  end

  // next flag and mask state, combined lines and exception line
  always_comb begin
    newc = '0;
    exc  = 1'b0;
    for (int k = 0; k < NG; k++) begin
      raised[k] = '0;
      if (op_q == dsp_eic_pkg::OP_PULSE && eg_q == 2'(k) && k < EVENT_GROUPS) begin
        raised[k] = eb_q;
      end
      if (set_en && grp == 2'(k)) begin
        raised[k] = raised[k] | wd_q;
      end
      if (k == 0) begin
        raised[k] = raised[k] & dsp_eic_pkg::RESERVED_KEEP;
      end
      flags_next[k]  = (flags[k] & ~((clr_en && grp == 2'(k)) ? wd_q : '0)) | raised[k];
      masks_next[k]  = (mask_we && grp == 2'(k)) ? wd_q : masks[k];
      xmasks_next[k] = (xmask_we && grp == 2'(k)) ? wd_q : xmasks[k];
      newc[k] = |(flags_next[k] & ~masks_next[k]);
      exc     = exc | (|(flags_next[k] & ~xmasks_next[k]));
    end
  end

  assign rise       = newc & ~last_comb;
  assign raised_all = {raised[3], raised[2], raised[1], raised[0]};

  genvar k, i, n, w;

  for (k = 0; k < NG; k++) begin : g_grp
    if (k < EVENT_GROUPS) begin : g_live
      logic [GW-1:0] f_q;
      logic [GW-1:0] m_q;
      logic [GW-1:0] x_q;
      always_ff @(posedge clk) begin
        if (rst) begin
          f_q <= '0;
          m_q <= '1;
          x_q <= '1;
        end else if (cmd.exec) begin
          f_q <= flags_next[k];
          m_q <= masks_next[k];
          x_q <= xmasks_next[k];
        end
      end
      assign flags[k]  = f_q;
      assign masks[k]  = m_q;
      assign xmasks[k] = x_q;
    end else begin : g_absent
      // no events: nothing ever flags or unmasks
      assign flags[k]  = '0;
      assign masks[k]  = '1;
      assign xmasks[k] = '1;
    end
  end

  // interrupt selectors, four per mux word starting at word 1
  for (i = 0; i < NS; i++) begin : g_sel
    localparam logic [1:0] WORD = 2'(i / dsp_eic_pkg::SEL_PER_WORD + 1);
    localparam int         LSB  = 8 * (i % dsp_eic_pkg::SEL_PER_WORD);
    always_ff @(posedge clk) begin
      if (rst) begin
        sel[i] <= '0;
      end else if (cmd.exec && mux_we && grp == WORD) begin
        sel[i] <= wd_q[LSB +: SW];
      end
    end
  end

  assign mux_word[0] = '0;
  for (w = 1; w < NG; w++) begin : g_mword
    localparam int B = (w - 1) * dsp_eic_pkg::SEL_PER_WORD;
    assign mux_word[w] = {1'b0, sel[B+3], 1'b0, sel[B+2], 1'b0, sel[B+1], 1'b0, sel[B]};
  end

  for (n = 0; n < dsp_eic_pkg::NUM_IRQ; n++) begin : g_irq
    if (n >= dsp_eic_pkg::FIXED_IRQS && n >= FIRST_MAPPABLE_IRQ) begin : g_map
      logic [SW-1:0] e;
      assign e        = sel[n - dsp_eic_pkg::FIXED_IRQS];
      // events 0..3 are the combined lines: pulse on their rising edge
      assign pulse[n] = (e < SW'(4)) ? rise[e[1:0]] : raised_all[e];
    end else begin : g_fixed
      assign pulse[n] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_comb <= '0;
    end else if (cmd.exec) begin
      last_comb <= newc;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      read_data     <= rd;
      exception_out <= exc;
      cpu_irq_pulse <= pulse;
      bad_access    <= bad;
    end
  end

  assign combined_events = last_comb;

endmodule

/* rtl/core/dsp_eic_checker.sv */
module dsp_eic_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] read_data,
  input logic [15:0] cpu_irq_pulse
);

  a_reset_empty: assert property (@(posedge clk) $past(rst) |-> !out_valid)
    else $error("result valid right after reset");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with no result pending");

  a_latency: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && !out_valid) |-> ##2 out_valid)
    else $error("accepted word produced no result");

  a_fixed_irqs: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> cpu_irq_pulse[3:0] == 4'd0)
    else $error("fixed interrupt pulsed");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(read_data)))
    else $error("stalled result changed");

endmodule

bind dsp_event_interrupt_controller dsp_eic_checker u_chk (.*);

/* test/tb.sv */
`timescale 1ns / 1ps

// Self-checking bench for the event interrupt controller.
// A driver pops words from a pending queue onto the input channel; a monitor
// runs every accepted word through a local model of the flags, masks and
// interrupt selectors and compares each result word with the oldest
// prediction. Phases vary sender gaps and receiver stalls, one phase holds
// the receiver off long enough to back the block up, and the sender drains
// between phases.
module tb;

  localparam int EVENT_GROUPS       = 4;
  localparam int FIRST_MAPPABLE_IRQ = 4;
  localparam int HOLD_CYCLES        = 300;  // long receiver hold-off
  localparam int DRAIN_CYCLES       = 8;    // margin after the queues empty

  typedef enum logic [2:0] {
    PH_DIRECTED, PH_FREE, PH_SEND_GAPS, PH_RECV_STALLS, PH_BOTH, PH_HOLD
  } phase_t;

  // one input word
  typedef struct packed {
    logic [1:0]  op;
    logic [6:0]  reg_word;
    logic [31:0] write_data;
    logic [1:0]  event_group;
    logic [31:0] event_bits;
  } word_t;

  // one result word
  typedef struct packed {
    logic [31:0] read_data;
    logic [3:0]  combined;
    logic        exception;
    logic [15:0] irq_pulse;
    logic        bad;
  } result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  op = dsp_eic_pkg::OP_IDLE;
  logic [6:0]  reg_word = '0;
  logic [31:0] write_data = '0;
  logic [1:0]  event_group = '0;
  logic [31:0] event_bits = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] read_data;
  logic [3:0]  combined_events;
  logic        exception_out;
  logic [15:0] cpu_irq_pulse;
  logic        bad_access;

  phase_t phase = PH_DIRECTED;
  int     errors = 0;
  int     hold_left = 0;
  logic   hold_begun = 1'b0;

  word_t   pend_q[$];    // words waiting to be driven
  result_t result_q[$];  // predicted result words, oldest first

  // local copy of the controller state
  logic [31:0]                   flag_q  [dsp_eic_pkg::NUM_GROUPS];
  logic [31:0]                   mask_q  [dsp_eic_pkg::NUM_GROUPS];
  logic [31:0]                   xmask_q [dsp_eic_pkg::NUM_GROUPS];
  logic [dsp_eic_pkg::SEL_W-1:0] sel_q   [dsp_eic_pkg::NUM_SEL];
  logic [3:0]                    last_comb;

  dsp_event_interrupt_controller #(
    .EVENT_GROUPS       (EVENT_GROUPS),
    .FIRST_MAPPABLE_IRQ (FIRST_MAPPABLE_IRQ)
  ) u_dut (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .op              (op),
    .reg_word        (reg_word),
    .write_data      (write_data),
    .event_group     (event_group),
    .event_bits      (event_bits),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .read_data       (read_data),
    .combined_events (combined_events),
    .exception_out   (exception_out),
    .cpu_irq_pulse   (cpu_irq_pulse),
    .bad_access      (bad_access)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Apply one accepted word to the local state and queue the result it
  // should produce.
  task automatic update_controller(input word_t w);
    logic [31:0] raised [dsp_eic_pkg::NUM_GROUPS];
    result_t     r;
    logic [4:0]  bank;
    logic [1:0]  g;
    logic        wr;
    logic [3:0]  rise;
    logic [6:0]  e;
    logic        hit;
    int          base;
    raised = '{default: '0};
    r = '0;
    bank = w.reg_word[6:2];
    g = w.reg_word[1:0];
    wr = (w.op == dsp_eic_pkg::OP_WRITE);
    base = (int'(g) - 1) * dsp_eic_pkg::SEL_PER_WORD;
    if (w.op == dsp_eic_pkg::OP_PULSE) begin
      // pulses into a group the block does not have are dropped
      if (w.event_group < EVENT_GROUPS) raised[w.event_group] = w.event_bits;
    end else if (w.op == dsp_eic_pkg::OP_READ || w.op == dsp_eic_pkg::OP_WRITE) begin
      if (bank == dsp_eic_pkg::BANK_MUX) begin
        // mux word 0 would be interrupts 0..3, which are fixed: unmapped
        if (g == 2'd0) r.bad = 1'b1;
        else begin
          for (int n = 0; n < dsp_eic_pkg::SEL_PER_WORD; n++) begin
            if (wr) sel_q[base + n] = w.write_data[8*n +: dsp_eic_pkg::SEL_W];
            else r.read_data[8*n +: dsp_eic_pkg::SEL_W] = sel_q[base + n];
          end
        end
      end else if (g >= EVENT_GROUPS) begin
        r.bad = 1'b1;
      end else begin
        case (bank)
          dsp_eic_pkg::BANK_FLAG: begin
            if (wr) r.bad = 1'b1; else r.read_data = flag_q[g];
          end
          dsp_eic_pkg::BANK_SET: begin
            if (wr) raised[g] = w.write_data;
          end
          dsp_eic_pkg::BANK_CLR: begin
            if (wr) flag_q[g] &= ~w.write_data;
          end
          dsp_eic_pkg::BANK_MASK: begin
            if (wr) mask_q[g] = w.write_data; else r.read_data = mask_q[g];
          end
          dsp_eic_pkg::BANK_MFLAG: begin
            if (wr) r.bad = 1'b1; else r.read_data = flag_q[g] & ~mask_q[g];
          end
          dsp_eic_pkg::BANK_XMASK: begin
            if (wr) xmask_q[g] = w.write_data; else r.read_data = xmask_q[g];
          end
          dsp_eic_pkg::BANK_XFLAG: begin
            if (wr) r.bad = 1'b1; else r.read_data = flag_q[g] & ~xmask_q[g];
          end
          default: r.bad = 1'b1;
        endcase
      end
    end

    // events 0..3 are the combined lines themselves and never latch
    raised[0] &= dsp_eic_pkg::RESERVED_KEEP;
    for (int k = 0; k < dsp_eic_pkg::NUM_GROUPS; k++) begin
      flag_q[k] |= raised[k];
      if ((flag_q[k] & ~mask_q[k]) != '0) r.combined[k] = 1'b1;
      if ((flag_q[k] & ~xmask_q[k]) != '0) r.exception = 1'b1;
    end
    rise = r.combined & ~last_comb;
    last_comb = r.combined;

    // a selector below 4 follows a combined line's rising edge; any other
    // selector follows the raw raise of its event in this word
    for (int n = dsp_eic_pkg::FIXED_IRQS; n < dsp_eic_pkg::NUM_IRQ; n++) begin
      if (n >= FIRST_MAPPABLE_IRQ) begin
        e = sel_q[n - dsp_eic_pkg::FIXED_IRQS];
        if (e < dsp_eic_pkg::NUM_GROUPS) hit = rise[e[1:0]];
        else hit = raised[e[6:5]][e[4:0]];
        r.irq_pulse[n] = hit;
      end
    end
    result_q.push_back(r);
  endtask

  task automatic queue_word(input logic [1:0] o, input logic [6:0] rw,
                            input logic [31:0] wd, input logic [1:0] eg,
                            input logic [31:0] eb);
    word_t w;
    w.op = o;
    w.reg_word = rw;
    w.write_data = wd;
    w.event_group = eg;
    w.event_bits = eb;
    pend_q.push_back(w);
  endtask

  // dense, sparse, one-hot and the two extremes
  function automatic logic [31:0] rand_bits();
    case ($urandom_range(0, 6))
      0, 1:    return $urandom & $urandom & $urandom;
      2:       return 32'h1 << $urandom_range(0, 31);
      3:       return '0;
      4:       return '1;
      default: return $urandom;
    endcase
  endfunction

  // selector bytes lean toward the combined lines so their edges get mapped
  function automatic logic [31:0] rand_selectors();
    logic [31:0] d;
    d = $urandom;
    for (int n = 0; n < dsp_eic_pkg::SEL_PER_WORD; n++)
      if ($urandom_range(0, 2) == 0) d[8*n +: 2] = 2'($urandom_range(0, 3)) & 2'b11;
    for (int n = 0; n < dsp_eic_pkg::SEL_PER_WORD; n++)
      if ($urandom_range(0, 3) == 0) d[8*n+2 +: 5] = '0;
    return d;
  endfunction

  function automatic logic [4:0] rand_bank();
    case ($urandom_range(0, 7))
      0:       return dsp_eic_pkg::BANK_FLAG;
      1:       return dsp_eic_pkg::BANK_SET;
      2:       return dsp_eic_pkg::BANK_CLR;
      3:       return dsp_eic_pkg::BANK_MASK;
      4:       return dsp_eic_pkg::BANK_MFLAG;
      5:       return dsp_eic_pkg::BANK_XMASK;
      6:       return dsp_eic_pkg::BANK_XFLAG;
      default: return dsp_eic_pkg::BANK_MUX;
    endcase
  endfunction

  // Mostly well-formed traffic: pulses, set/clear/mask/mux writes and reads
  // of mapped offsets. A small share is idle ops and raw random offsets.
  function automatic word_t random_word();
    word_t w;
    int    pick;
    w.op = dsp_eic_pkg::OP_READ;
    w.reg_word = 7'($urandom);
    w.write_data = rand_bits();
    w.event_group = 2'($urandom);
    w.event_bits = rand_bits();
    pick = $urandom_range(0, 99);
    if (pick < 28) begin
      w.op = dsp_eic_pkg::OP_PULSE;
    end else if (pick < 62) begin
      w.op = dsp_eic_pkg::OP_WRITE;
      case ($urandom_range(0, 9))
        0, 1: w.reg_word = {dsp_eic_pkg::BANK_SET, 2'($urandom_range(0, 3))};
        2, 3: w.reg_word = {dsp_eic_pkg::BANK_CLR, 2'($urandom_range(0, 3))};
        4:    w.reg_word = {dsp_eic_pkg::BANK_MASK, 2'($urandom_range(0, 3))};
        5:    w.reg_word = {dsp_eic_pkg::BANK_XMASK, 2'($urandom_range(0, 3))};
        6, 7: begin
          w.reg_word = {dsp_eic_pkg::BANK_MUX, 2'($urandom_range(1, 3))};
          w.write_data = rand_selectors();
        end
        8:    w.reg_word = {rand_bank(), 2'($urandom_range(0, 3))};
        default: ;
      endcase
    end else if (pick < 95) begin
      w.reg_word = {rand_bank(), 2'($urandom_range(0, 3))};
    end else if (pick < 97) begin
      w.op = dsp_eic_pkg::OP_IDLE;
    end else begin
      w.op = ($urandom_range(0, 1) == 0) ? dsp_eic_pkg::OP_READ : dsp_eic_pkg::OP_WRITE;
    end
    return w;
  endfunction

  // sampled on the falling edge so queue and valid updates have settled
  task automatic wait_drained();
    while (pend_q.size() != 0 || in_valid || result_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Input driver: a new word goes out only once the last one was taken.
  always @(posedge clk) begin : driver_p
    word_t nxt;
    int    gap_pct;
    case (phase)
      PH_SEND_GAPS: gap_pct = 62;
      PH_BOTH:      gap_pct = 34;
      default:      gap_pct = 0;
    endcase
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (pend_q.size() != 0 && $urandom_range(0, 99) >= gap_pct) begin
        nxt = pend_q.pop_front();
        op <= nxt.op;
        reg_word <= nxt.reg_word;
        write_data <= nxt.write_data;
        event_group <= nxt.event_group;
        event_bits <= nxt.event_bits;
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result-side ready. In the hold phase the receiver first backs off for a
  // long fixed stretch while the sender keeps offering words.
  always @(posedge clk) begin : receiver_p
    int stall_pct;
    case (phase)
      PH_RECV_STALLS: stall_pct = 62;
      PH_BOTH:        stall_pct = 34;
      default:        stall_pct = 0;
    endcase
    if (rst) begin
      out_ready <= 1'b0;
      hold_left <= 0;
      hold_begun <= 1'b0;
    end else if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (phase == PH_HOLD && !hold_begun) begin
      hold_begun <= 1'b1;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // Monitor: predict on input accept, check on result accept.
  always @(posedge clk) begin : monitor_p
    word_t   acc;
    result_t want;
    if (!rst) begin
      if (in_valid && in_ready) begin
        acc.op = op;
        acc.reg_word = reg_word;
        acc.write_data = write_data;
        acc.event_group = event_group;
        acc.event_bits = event_bits;
        update_controller(acc);
      end
      if (out_valid && out_ready) begin
        if (result_q.size() == 0) begin
          $error("result word with no prediction pending");
          errors++;
        end else begin
          want = result_q.pop_front();
          if (read_data !== want.read_data) begin
            $error("read_data: expected %h, got %h", want.read_data, read_data);
            errors++;
          end
          if (combined_events !== want.combined) begin
            $error("combined_events: expected %h, got %h", want.combined, combined_events);
            errors++;
          end
          if (exception_out !== want.exception) begin
            $error("exception_out: expected %b, got %b", want.exception, exception_out);
            errors++;
          end
          if (cpu_irq_pulse !== want.irq_pulse) begin
            $error("cpu_irq_pulse: expected %h, got %h", want.irq_pulse, cpu_irq_pulse);
            errors++;
          end
          if (bad_access !== want.bad) begin
            $error("bad_access: expected %b, got %b", want.bad, bad_access);
            errors++;
          end
        end
      end
    end
  end

  initial begin : stimulus_p
    for (int k = 0; k < dsp_eic_pkg::NUM_GROUPS; k++) begin
      flag_q[k] = '0;
      mask_q[k] = '1;
      xmask_q[k] = '1;
    end
    for (int k = 0; k < dsp_eic_pkg::NUM_SEL; k++) sel_q[k] = '0;
    last_comb = '0;

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // directed: reset values, mux fields (bit 7 of each byte dropped),
    // reserved low events, register access errors, write-only reads
    queue_word(dsp_eic_pkg::OP_READ,  {dsp_eic_pkg::BANK_FLAG, 2'd0},  '0, 2'd0, '1);
    queue_word(dsp_eic_pkg::OP_READ,  {dsp_eic_pkg::BANK_MASK, 2'd0},  '0, 2'd0, '0);
    queue_word(dsp_eic_pkg::OP_READ,  {dsp_eic_pkg::BANK_XMASK, 2'd3}, '1, 2'd3, '0);
    queue_word(dsp_eic_pkg::OP_WRITE, {dsp_eic_pkg::BANK_MASK, 2'd0},  '0, 2'd0, '0);
    queue_word(dsp_eic_pkg::OP_WRITE, {dsp_eic_pkg::BANK_MASK, 2'd1},  '0, 2'd0, '0);
    queue_word(dsp_eic_pkg::OP_WRITE, {dsp_eic_pkg::BANK_MUX, 2'd1},
               32'hFF04_8180, 2'd0, '0);
    queue_word(dsp_eic_pkg::OP_WRITE, {dsp_eic_pkg::BANK_MUX, 2'd2},
               32'h2423_2221, 2'd0, '0);
    queue_word(dsp_eic_pkg::OP_WRITE, {dsp_eic_pkg::BANK_MUX, 2'd3},
               32'h7E40_0302, 2'd0, '0);
    queue_word(dsp_eic_pkg::OP_READ,  {dsp_eic_pkg::BANK_MUX, 2'd1},   '0, 2'd0, '0);
    queue_word(dsp_eic_pkg::OP_READ,  {dsp_eic_pkg::BANK_MUX, 2'd3},   '0, 2'd0, '0);
    queue_word(dsp_eic_pkg::OP_READ,  {dsp_eic_pkg::BANK_MUX, 2'd0},   '0, 2'd0, '0);
    queue_word(dsp_eic_pkg::OP_PULSE, 7'd0, '0, 2'd0, 32'hFFFF_FFFF);
    queue_word(dsp_eic_pkg::OP_PULSE, 7'd0, '0, 2'd1, 32'h0000_001E);
    queue_word(dsp_eic_pkg::OP_WRITE, {dsp_eic_pkg::BANK_SET, 2'd3},
               32'h8000_0000, 2'd0, '0);
    queue_word(dsp_eic_pkg::OP_WRITE, {dsp_eic_pkg::BANK_FLAG, 2'd1},  '1, 2'd0, '0);
    queue_word(dsp_eic_pkg::OP_WRITE, {dsp_eic_pkg::BANK_MFLAG, 2'd0}, '1, 2'd0, '0);
    queue_word(dsp_eic_pkg::OP_WRITE, {dsp_eic_pkg::BANK_XFLAG, 2'd2}, '1, 2'd0, '0);
    queue_word(dsp_eic_pkg::OP_READ,  {dsp_eic_pkg::BANK_SET, 2'd1},   '0, 2'd0, '0);
    queue_word(dsp_eic_pkg::OP_READ,  {dsp_eic_pkg::BANK_CLR, 2'd2},   '0, 2'd0, '0);
    queue_word(dsp_eic_pkg::OP_WRITE, {dsp_eic_pkg::BANK_CLR, 2'd0},   '1, 2'd0, '0);
    queue_word(dsp_eic_pkg::OP_WRITE, {dsp_eic_pkg::BANK_XMASK, 2'd2}, '0, 2'd0, '0);
    queue_word(dsp_eic_pkg::OP_WRITE, {dsp_eic_pkg::BANK_SET, 2'd2},
               32'h0000_0020, 2'd0, '0);
    queue_word(dsp_eic_pkg::OP_READ,  {dsp_eic_pkg::BANK_MFLAG, 2'd1}, '0, 2'd0, '0);
    queue_word(dsp_eic_pkg::OP_READ,  {dsp_eic_pkg::BANK_XFLAG, 2'd2}, '0, 2'd0, '0);
    queue_word(dsp_eic_pkg::OP_READ,  7'd127, '0, 2'd0, '0);
    queue_word(dsp_eic_pkg::OP_WRITE, 7'd24,  '1, 2'd0, '0);
    queue_word(dsp_eic_pkg::OP_IDLE,  7'd0,   '1, 2'd3, '1);
    queue_word(dsp_eic_pkg::OP_PULSE, 7'd0,   '0, 2'd0, 32'h0000_000F);
    wait_drained();

    // random traffic; the sender drains fully between phases
    phase <= PH_FREE;
    for (int i = 0; i < 300; i++) pend_q.push_back(random_word());
    wait_drained();
    phase <= PH_SEND_GAPS;
    for (int i = 0; i < 300; i++) pend_q.push_back(random_word());
    wait_drained();
    phase <= PH_RECV_STALLS;
    for (int i = 0; i < 300; i++) pend_q.push_back(random_word());
    wait_drained();
    phase <= PH_BOTH;
    for (int i = 0; i < 400; i++) pend_q.push_back(random_word());
    wait_drained();
    // receiver held off while words keep coming: the block must back up
    phase <= PH_HOLD;
    for (int i = 0; i < 150; i++) pend_q.push_back(random_word());
    wait_drained();

    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin : watchdog_p
    #4_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

/* files.f */
rtl/core/dsp_eic_pkg.sv
rtl/core/dsp_eic_ctrl.sv
rtl/core/dsp_eic_datapath.sv
rtl/core/dsp_event_interrupt_controller.sv
rtl/core/dsp_eic_checker.sv
test/tb.sv
